[rtl/c128d_pkg.sv]
// ----------------------------------------------------------------------------
// c128d_pkg
// Types, round constants and round functions shared by the decrypt datapath.
// ----------------------------------------------------------------------------
package c128d_pkg;

    localparam int NUM_ROUNDS = 12;
    localparam int NUM_ROWS   = 4;

    typedef logic [31:0] t_word;
    typedef logic [NUM_ROWS-1:0][31:0] t_block;

    typedef enum logic [1:0] {
        TK_ZERO = 2'd0,
        TK_ONE  = 2'd1,
        TK_TWO  = 2'd2
    } t_tk_sel;

    typedef struct packed {
        logic [NUM_ROWS-1:0] rcon;
        logic                tk_en;
        t_tk_sel             tk_sel;
    } t_stage_ctl;

    // bit i of an entry is the constant for row i
    localparam logic [NUM_ROWS-1:0] RCON [NUM_ROUNDS] = '{
        4'b0001, 4'b0010, 4'b0100, 4'b1000,
        4'b0011, 4'b0110, 4'b1100, 4'b1011,
        4'b0101, 4'b1010, 4'b0111, 4'b1110
    };

    function automatic t_word rotr(input t_word v, input int unsigned n);
        logic [63:0] w;
        w = {v, v} >> n;
        return w[31:0];
    endfunction

    function automatic t_block tweakey(input t_tk_sel sel, input t_block t, input t_block k);
        t_block tk;
        unique case (sel)
            TK_ZERO: begin
                tk = t;
            end
            TK_ONE: begin
                tk[0] = t[0] ^ t[2];
                tk[1] = t[1] ^ t[3];
                tk[2] = t[0];
                tk[3] = t[1];
            end
            TK_TWO: begin
                tk[0] = t[2];
                tk[1] = t[3];
                tk[2] = t[0] ^ t[2];
                tk[3] = t[1] ^ t[3];
            end
            default: begin
                tk = t;
            end
        endcase
        return tk ^ k;
    endfunction

    function automatic logic [63:0] inv_lbox(input t_word p, input t_word q);
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        a = p ^ rotr(p, 25);
        b = q ^ rotr(q, 25);
        c = p ^ rotr(a, 31);
        d = q ^ rotr(b, 31);
        c = c ^ rotr(a, 20);
        d = d ^ rotr(b, 20);
        a = c ^ rotr(c, 31);
        b = d ^ rotr(d, 31);
        c = c ^ rotr(b, 26);
        d = d ^ rotr(a, 25);
        a = a ^ rotr(c, 17);
        b = b ^ rotr(d, 17);
        return {rotr(b, 16), rotr(a, 16)};
    endfunction

    function automatic t_block inv_sbox(input t_block w);
        t_block q;
        q[3] = (w[0] & w[1]) ^ w[2];
        q[0] = (w[1] & q[3]) ^ w[3];
        q[1] = (q[3] & q[0]) ^ w[0];
        q[2] = (q[0] & q[1]) ^ w[1];
        return q;
    endfunction

    function automatic t_block inv_round(input t_block w, input logic [NUM_ROWS-1:0] rc);
        t_block      x;
        logic [63:0] lo;
        logic [63:0] hi;
        for (int i = 0; i < NUM_ROWS; i++) begin
            x[i] = w[i] ^ {31'd0, rc[i]};
        end
        lo = inv_lbox(x[0], x[1]);
        hi = inv_lbox(x[2], x[3]);
        x[0] = lo[31:0];
        x[1] = lo[63:32];
        x[2] = hi[31:0];
        x[3] = hi[63:32];
        return inv_sbox(x);
    endfunction

endpackage

[rtl/clyde128_decrypt_unit.sv]
// ----------------------------------------------------------------------------
// clyde128_decrypt_unit
// Clyde-128 tweakable block decryption, one block per clock.
// ----------------------------------------------------------------------------
// usage
//   request channel: pulse i_start with the ciphertext rows and tweak words;
//   o_busy is always low, so a request is taken on every cycle i_start is high
//   result channel: o_valid strobes for one cycle with the plaintext rows;
//   the receiver cannot stall, and none is needed since nothing is buffered
//   pipeline: an accepted request passes through twelve inverse-round stages
//   and then the output register before the result is taken
//   throughput: one block per cycle, set by one inverse round per stage
//   key: written through i_cfg_we / i_cfg_index / i_cfg_data while no request
//   is in flight; stages read the key registers directly
//   reset: clears the key to zero and drops all stage valid bits; requests in
//   flight at reset are discarded
// ----------------------------------------------------------------------------
module clyde128_decrypt_unit
    import c128d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_cipher_row0,
    input  logic [31:0] i_cipher_row1,
    input  logic [31:0] i_cipher_row2,
    input  logic [31:0] i_cipher_row3,
    input  logic [31:0] i_tweak_row0,
    input  logic [31:0] i_tweak_row1,
    input  logic [31:0] i_tweak_row2,
    input  logic [31:0] i_tweak_row3,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [31:0] o_plain_row0,
    output logic [31:0] o_plain_row1,
    output logic [31:0] o_plain_row2,
    output logic [31:0] o_plain_row3
);

    t_block              r_key;
    logic                r_out_valid;
    t_block              r_plain;
    logic [NUM_ROUNDS:0] w_valid;
    t_block              w_state [NUM_ROUNDS+1];
    t_block              w_tweak [NUM_ROUNDS+1];
    t_stage_ctl          w_ctl   [NUM_ROUNDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_busy     = 1'b0;
    assign w_valid[0] = i_start & ~o_busy;
    assign w_state[0] = {i_cipher_row3, i_cipher_row2, i_cipher_row1, i_cipher_row0};
    assign w_tweak[0] = {i_tweak_row3, i_tweak_row2, i_tweak_row1, i_tweak_row0};

    // stage g runs inverse round NUM_ROUNDS-1-g
    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_stage
        localparam int RND = NUM_ROUNDS - 1 - g;
        localparam int SEL = ((RND / 2) + 1) % 3;

        assign w_ctl[g].rcon   = RCON[RND];
        assign w_ctl[g].tk_en  = ((RND % 2) == 1);
        assign w_ctl[g].tk_sel = t_tk_sel'(SEL[1:0]);

        c128d_round_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_key   (r_key),
            .i_valid (w_valid[g]),
            .i_state (w_state[g]),
            .i_tweak (w_tweak[g]),
            .o_valid (w_valid[g+1]),
            .o_state (w_state[g+1]),
            .o_tweak (w_tweak[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_valid[NUM_ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_plain <= w_state[NUM_ROUNDS] ^ tweakey(TK_ZERO, w_tweak[NUM_ROUNDS], r_key);
    end

    assign o_valid      = r_out_valid;
    assign o_plain_row0 = r_plain[0];
    assign o_plain_row1 = r_plain[1];
    assign o_plain_row2 = r_plain[2];
    assign o_plain_row3 = r_plain[3];

`ifndef SYNTHESIS
    a_out_follows_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_valid == $past(w_valid[NUM_ROUNDS])))
        else $error("result strobe does not follow the last stage");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe set right after reset");

    a_key_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_rst_n) |=> (r_key[$past(i_cfg_index)] == $past(i_cfg_data)))
        else $error("key word not written");
`endif

endmodule

[rtl/c128d_round_stage.sv]
// ----------------------------------------------------------------------------
// c128d_round_stage
// One pipeline stage: optional tweakey add, one inverse round, registered.
// ----------------------------------------------------------------------------
module c128d_round_stage
    import c128d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stage_ctl i_ctl,
    input  t_block     i_key,
    input  logic       i_valid,
    input  t_block     i_state,
    input  t_block     i_tweak,
    output logic       o_valid,
    output t_block     o_state,
    output t_block     o_tweak
);

    logic   r_valid;
    t_block r_state;
    t_block r_tweak;
    t_block n_state;
    t_block w_mixed;

    always_comb begin
        w_mixed = i_state;
        if (i_ctl.tk_en) begin
            w_mixed = i_state ^ tweakey(i_ctl.tk_sel, i_tweak, i_key);
        end
        n_state = inv_round(w_mixed, i_ctl.rcon);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_tweak <= i_tweak;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_tweak = r_tweak;

endmodule
